>>> src/odo_pkg.sv
// ----------------------------------------------------------------------------
// odo_pkg: shared types and constants for the odometry block
// Request payload types, register codes, fixed-point widths and the
// CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package odo_pkg;

    localparam int ODO_CORDIC_STEPS = 16;
    localparam int ODO_MAX_STEPS    = 24;

    // CORDIC datapath width and width of the rounded Q.20 sine/cosine
    localparam int CORDIC_W = 34;
    localparam int C20_W    = 23;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_DIST = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN      = 1'd1;

    localparam logic [31:0] HALF_DIST_RST = 32'd16013653;
    localparam logic [31:0] TURN_RST      = 32'd3036877;

    typedef struct packed {
        logic signed [15:0] left_degrees;
        logic signed [15:0] right_degrees;
    } t_in;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] heading;
    } t_out;

    // atan(2^-i) with 2^32 as one full turn
    function automatic logic [31:0] odo_atan(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> src/odo_cordic.sv
// ----------------------------------------------------------------------------
// odo_cordic: iterative rotation-mode CORDIC
// Folds the angle into the right half plane, then runs one shift-add
// micro-rotation per cycle. Gives cosine and sine rounded to Q.20.
// ----------------------------------------------------------------------------
`default_nettype none

module odo_cordic #(
    parameter int STEPS = odo_pkg::ODO_CORDIC_STEPS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [31:0]                        i_angle,
    output logic                               o_done,
    output logic signed [odo_pkg::C20_W-1:0]   o_cos20,
    output logic signed [odo_pkg::C20_W-1:0]   o_sin20
);
    import odo_pkg::*;

    localparam int N     = (STEPS > ODO_MAX_STEPS) ? ODO_MAX_STEPS : STEPS;
    localparam int CNT_W = (N > 1) ? $clog2(N) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(N - 1);

    localparam logic signed [CORDIC_W-1:0] X_INIT = CORDIC_W'(652032874);

    logic                       r_busy;
    logic                       r_done;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_neg;
    logic signed [CORDIC_W-1:0] r_x;
    logic signed [CORDIC_W-1:0] r_y;
    logic signed [CORDIC_W-1:0] r_z;

    logic                       fold;
    logic [31:0]                ang_f;
    logic signed [CORDIC_W-1:0] x_sh;
    logic signed [CORDIC_W-1:0] y_sh;
    logic signed [CORDIC_W-1:0] atan_v;
    logic signed [CORDIC_W-1:0] c_val;
    logic signed [CORDIC_W-1:0] s_val;
    logic signed [CORDIC_W-1:0] c_rnd;
    logic signed [CORDIC_W-1:0] s_rnd;

    // angle in the left half plane: rotate by pi and negate the results
    assign fold   = i_angle[31] ^ i_angle[30];
    assign ang_f  = fold ? {~i_angle[31], i_angle[30:0]} : i_angle;

    assign x_sh   = r_x >>> r_cnt;
    assign y_sh   = r_y >>> r_cnt;
    assign atan_v = CORDIC_W'(signed'({1'b0, odo_atan(5'(r_cnt))}));

    assign c_val  = r_neg ? -r_x : r_x;
    assign s_val  = r_neg ? -r_y : r_y;
    assign c_rnd  = c_val + CORDIC_W'(512);
    assign s_rnd  = s_val + CORDIC_W'(512);

    assign o_cos20 = C20_W'(c_rnd >>> 10);
    assign o_sin20 = C20_W'(s_rnd >>> 10);
    assign o_done  = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= fold;
            r_x   <= X_INIT;
            r_y   <= '0;
            r_z   <= CORDIC_W'(signed'(ang_f));
        end else if (r_busy) begin
            if (r_z >= 0) begin
                r_x <= r_x - y_sh;
                r_y <= r_y + x_sh;
                r_z <= r_z - atan_v;
            end else begin
                r_x <= r_x + y_sh;
                r_y <= r_y - x_sh;
                r_z <= r_z + atan_v;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/differential_drive_odometry.sv
// Takes one request at a time; o_in_stall stays high while one is in work or while its
// result waits on i_out_stall.
// The CORDIC takes one cycle per micro-rotation; one shared 33x23 multiplier serves
// the distance, the turn and both two-part position products over six passes.
// Reset (synchronous, active low) clears position and heading to zero and restores both.
// ----------------------------------------------------------------------------
// differential_drive_odometry: dead-reckoning pose update
// Turns left/right encoder degrees into distance and turn, rotates the
// distance by the mid-step heading and accumulates a saturating x/y position.
// ----------------------------------------------------------------------------
`default_nettype none

module differential_drive_odometry #(
    parameter int CORDIC_STEPS = odo_pkg::ODO_CORDIC_STEPS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  odo_pkg::t_in                    i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output odo_pkg::t_out                   o_out_data,
    input  logic                            i_cfg_we,
    input  logic [odo_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [31:0]                     i_cfg_data
);
    import odo_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MDS  = 4'd1;
    localparam logic [3:0] S_MDT  = 4'd2;
    localparam logic [3:0] S_ANG  = 4'd3;
    localparam logic [3:0] S_CORD = 4'd4;
    localparam logic [3:0] S_ML   = 4'd5;
    localparam logic [3:0] S_MH   = 4'd6;
    localparam logic [3:0] S_MS   = 4'd7;
    localparam logic [3:0] S_MU   = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0]               r_state;
    logic [3:0]               n_state;

    logic [31:0]              r_hd;
    logic [31:0]              r_turn;
    logic signed [31:0]       r_x;
    logic signed [31:0]       r_y;
    logic [15:0]              r_heading;
    logic                     r_axis;
    logic                     r_out_valid;
    t_out                     r_out;

    logic signed [16:0]       r_sum;
    logic signed [16:0]       r_diff;
    logic signed [55:0]       r_prod;
    logic signed [41:0]       r_ds8;
    logic signed [C20_W-1:0]  r_c20;
    logic signed [C20_W-1:0]  r_s20;
    logic signed [63:0]       r_acc;

    logic                     in_acc;
    logic                     out_free;
    logic signed [32:0]       mul_a;
    logic signed [22:0]       mul_b;
    logic signed [55:0]       mul_p;
    logic [49:0]              ds_rnd;
    logic [31:0]              hd_rnd;
    logic [31:0]              cor_angle;
    logic                     cor_start;
    logic                     cor_done;
    logic signed [C20_W-1:0]  cor_cos;
    logic signed [C20_W-1:0]  cor_sin;
    logic signed [35:0]       delta;
    logic signed [36:0]       pos_sum;
    logic signed [31:0]       pos_sat;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_MDS: begin
                mul_a = signed'({1'b0, r_hd});
                mul_b = 23'(r_sum);
            end
            S_MDT: begin
                mul_a = signed'({1'b0, r_turn});
                mul_b = 23'(r_diff);
            end
            S_ML: begin
                mul_a = signed'({12'b0, r_ds8[20:0]});
                mul_b = r_axis ? r_s20 : r_c20;
            end
            S_MH: begin
                mul_a = 33'(signed'(r_ds8[41:21]));
                mul_b = r_axis ? r_s20 : r_c20;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p     = mul_a * mul_b;
    assign ds_rnd    = r_prod[49:0] + 50'd128;
    assign hd_rnd    = r_prod[31:0] + 32'h8000;
    assign cor_angle = {r_heading, 16'b0} + r_prod[32:1];
    assign cor_start = (r_state == S_ANG);

    // position step and saturation
    assign delta   = r_acc[63:28];
    assign pos_sum = r_axis ? (37'(r_y) - 37'(delta)) : (37'(r_x) + 37'(delta));
    assign pos_sat = (pos_sum[36:31] != {6{pos_sum[36]}}) ?
                     (pos_sum[36] ? 32'sh80000000 : 32'sh7FFFFFFF) : pos_sum[31:0];

    odo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_angle (cor_angle),
        .o_done  (cor_done),
        .o_cos20 (cor_cos),
        .o_sin20 (cor_sin)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_acc) n_state = S_MDS;
            S_MDS:   n_state = S_MDT;
            S_MDT:   n_state = S_ANG;
            S_ANG:   n_state = S_CORD;
            S_CORD:  if (cor_done) n_state = S_ML;
            S_ML:    n_state = S_MH;
            S_MH:    n_state = S_MS;
            S_MS:    n_state = S_MU;
            S_MU:    n_state = r_axis ? S_DONE : S_ML;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hd        <= HALF_DIST_RST;
            r_turn      <= TURN_RST;
            r_x         <= '0;
            r_y         <= '0;
            r_heading   <= '0;
            r_axis      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_HALF_DIST: r_hd   <= i_cfg_data;
                    CFG_TURN:      r_turn <= i_cfg_data;
                    default:       r_hd   <= r_hd;
                endcase
            end

            if (r_state == S_ANG) begin
                r_heading <= r_heading + hd_rnd[31:16];
                r_axis    <= 1'b0;
            end

            if (r_state == S_MU) begin
                if (r_axis) begin
                    r_y <= pos_sat;
                end else begin
                    r_x    <= pos_sat;
                    r_axis <= 1'b1;
                end
            end

            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_sum  <= 17'(i_in_data.right_degrees) + 17'(i_in_data.left_degrees);
                    r_diff <= 17'(i_in_data.right_degrees) - 17'(i_in_data.left_degrees);
                end
            end
            S_MDS: begin
                r_prod <= mul_p;
            end
            S_MDT: begin
                r_ds8  <= signed'(ds_rnd[49:8]);
                r_prod <= mul_p;
            end
            S_CORD: begin
                if (cor_done) begin
                    r_c20 <= cor_cos;
                    r_s20 <= cor_sin;
                end
            end
            S_ML: begin
                r_prod <= mul_p;
            end
            S_MH: begin
                r_acc  <= 64'(r_prod);
                r_prod <= mul_p;
            end
            S_MS: begin
                // fold in the high partial product and the rounding bias
                r_acc <= r_acc + (64'(r_prod) <<< 21) + 64'sd134217728;
            end
            S_DONE: begin
                if (out_free) begin
                    r_out.pos_x   <= r_x;
                    r_out.pos_y   <= r_y;
                    r_out.heading <= signed'(r_heading);
                end
            end
            default: begin
                r_prod <= r_prod;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for differential_drive_odometry
// Drives encoder-degree requests through the valid/stall handshake, predicts
// each pose update in fixed point (CORDIC heading, saturating x/y, wrapping
// heading) and compares every result field. Runs a short directed table, then
// random requests under several coefficient settings with random idling, one
// long output hold-off and a full drain before each register load.
// ----------------------------------------------------------------------------
module tb;
    import odo_pkg::*;

    localparam int ROT_STEPS      = ODO_CORDIC_STEPS;
    localparam int PHASE_ITEMS    = 210;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        bit   pinned;
        t_out pose;
    } t_pin;

    typedef struct {
        t_in  req;
        bit   pinned;
        t_out pose;
    } t_probe;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in         i_in_data  = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out        o_out_data;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = CFG_HALF_DIST;
    logic [31:0]          i_cfg_data = '0;

    // predicted pose and coefficients
    logic signed [31:0] pose_x         = '0;
    logic signed [31:0] pose_y         = '0;
    logic [15:0]        pose_heading   = '0;
    logic [31:0]        coef_half_dist = HALF_DIST_RST;
    logic [31:0]        coef_turn      = TURN_RST;

    t_out pose_q[$];
    t_pin fixed_q[$];
    int   faults      = 0;
    int   idle_cycles = 0;
    bit   steady      = 1'b0;
    bit   hold_req    = 1'b0;

    // atan(2^-i), one full turn is 2^32
    longint atan_turns [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    logic signed [15:0] corner_vals [5] = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};

    // only the row right after reset can be read off directly
    t_probe opening_rows [20] = '{
        '{'{16'sd0, 16'sd0}, 1'b1, '{32'sd0, 32'sd0, 16'sd0}},
        '{'{16'sd0, 16'sd1}, 1'b0, '0},
        '{'{16'sd1, 16'sd0}, 1'b0, '0},
        '{'{-16'sd1, 16'sd0}, 1'b0, '0},
        '{'{16'sd0, -16'sd1}, 1'b0, '0},
        '{'{16'sd1, -16'sd1}, 1'b0, '0},
        '{'{-16'sd1, 16'sd1}, 1'b0, '0},
        '{'{16'sh7FFF, 16'sh7FFF}, 1'b0, '0},
        '{'{16'sh8000, 16'sh8000}, 1'b0, '0},
        '{'{16'sh7FFF, 16'sh8000}, 1'b0, '0},
        '{'{16'sh8000, 16'sh7FFF}, 1'b0, '0},
        '{'{16'sh5555, 16'shAAAA}, 1'b0, '0},
        '{'{16'shAAAA, 16'sh5555}, 1'b0, '0},
        '{'{16'sd100, 16'sd100}, 1'b0, '0},
        '{'{-16'sd100, 16'sd100}, 1'b0, '0},
        '{'{16'sh7FFF, 16'sh8000}, 1'b0, '0},
        '{'{16'sd360, 16'sd360}, 1'b0, '0},
        '{'{16'sh8000, 16'sd0}, 1'b0, '0},
        '{'{16'sd0, 16'sh7FFF}, 1'b0, '0},
        '{'{16'sd0, 16'sd0}, 1'b0, '0}
    };

    differential_drive_odometry #(
        .CORDIC_STEPS(ROT_STEPS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // advance the predicted pose by one request and return the new pose
    function automatic t_out advance_pose(input t_in req);
        longint      dist_q16, dist_q8, turn_q16, z, vx, vy, nx, c20, s20, dx, dy;
        logic [63:0] turn_bits, step_bits;
        logic [31:0] angle, probe;
        bit          fold;
        t_out        res;
        dist_q16 = longint'({32'h0, coef_half_dist})
                 * (longint'(req.right_degrees) + longint'(req.left_degrees));
        turn_q16 = longint'({32'h0, coef_turn})
                 * (longint'(req.right_degrees) - longint'(req.left_degrees));
        turn_bits = turn_q16;
        // mid-step heading: th plus half the turn
        angle = {pose_heading, 16'h0000} + turn_bits[32:1];
        probe = angle + 32'h4000_0000;
        fold  = probe[31];
        if (fold) begin
            angle = angle - 32'h8000_0000;
        end
        z  = longint'($signed(angle));
        vx = 64'sd652032874;
        vy = 64'sd0;
        for (int i = 0; i < ROT_STEPS && i < ODO_MAX_STEPS; i++) begin
            nx = vx;
            if (z >= 0) begin
                vx = nx - (vy >>> i);
                vy = vy + (nx >>> i);
                z  = z - atan_turns[i];
            end else begin
                vx = nx + (vy >>> i);
                vy = vy - (nx >>> i);
                z  = z + atan_turns[i];
            end
        end
        if (fold) begin
            vx = -vx;
            vy = -vy;
        end
        c20     = (vx + 64'sd512) >>> 10;
        s20     = (vy + 64'sd512) >>> 10;
        dist_q8 = (dist_q16 + 64'sd128) >>> 8;
        dx = (dist_q8 * c20 + 64'sd134217728) >>> 28;
        dy = (dist_q8 * s20 + 64'sd134217728) >>> 28;
        pose_x = clamp32(longint'(pose_x) + dx);
        pose_y = clamp32(longint'(pose_y) - dy);
        step_bits    = turn_bits + 64'h8000;
        pose_heading = pose_heading + step_bits[31:16];
        res.pos_x   = pose_x;
        res.pos_y   = pose_y;
        res.heading = pose_heading;
        return res;
    endfunction

    task automatic send_update(input t_in req, input bit pinned, input t_out pose);
        fixed_q.push_back('{pinned, pose});
        i_in_data  <= req;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic sender_gap();
        if (!steady && $urandom_range(0, 99) < 26) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 36)) @(posedge i_clk);
        end
    endtask

    // drop valid and wait until every predicted pose has come back
    task automatic await_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pose_q.size() != 0);
    endtask

    task automatic load_coeffs(input logic [31:0] half, input logic [31:0] turn);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_HALF_DIST;
        i_cfg_data <= half;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_TURN;
        i_cfg_data <= turn;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin : stimulus
        t_in         req;
        t_out        blank;
        logic [31:0] half, turn;
        blank = '0;
        half  = HALF_DIST_RST;
        turn  = TURN_RST;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (opening_rows[k]) begin
            send_update(opening_rows[k].req, opening_rows[k].pinned, opening_rows[k].pose);
            sender_gap();
        end
        for (int ph = 0; ph < 8; ph++) begin
            await_results();
            case (ph)
                1: begin half = 32'h0;         turn = 32'h0;         end
                2: begin half = 32'hFFFF_FFFF; turn = 32'hFFFF_FFFF; end
                3: begin half = 32'hFFFF_FFFF; turn = 32'h0;         end
                4: begin half = 32'h0;         turn = 32'hFFFF_FFFF; end
                5: begin half = $urandom();    turn = $urandom();    end
                6: begin
                    half = $urandom_range(0, 32'h0400_0000);
                    turn = $urandom_range(0, 32'h0080_0000);
                end
                7: begin half = HALF_DIST_RST; turn = TURN_RST;      end
                default: ;
            endcase
            if (ph != 0) begin
                load_coeffs(half, turn);
            end
            steady = (ph == 3);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 0 && k == 60) begin
                    hold_req = 1'b1;
                end
                if (ph == 0 && k == 120) begin
                    await_results();
                end
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        req.left_degrees  = 16'($urandom());
                        req.right_degrees = 16'($urandom());
                    end
                    4, 5, 6: begin
                        req.left_degrees  = 16'($urandom_range(0, 400) - 200);
                        req.right_degrees = 16'($urandom_range(0, 400) - 200);
                    end
                    7: begin
                        req.left_degrees  = 16'($urandom());
                        req.right_degrees = req.left_degrees;
                    end
                    8: begin
                        req.left_degrees  = 16'($urandom());
                        req.right_degrees = -req.left_degrees;
                    end
                    default: begin
                        req.left_degrees  = corner_vals[$urandom_range(0, 4)];
                        req.right_degrees = corner_vals[$urandom_range(0, 4)];
                    end
                endcase
                send_update(req, 1'b0, blank);
                sender_gap();
            end
        end
        await_results();
        repeat (2 * (ROT_STEPS + 13)) @(posedge i_clk);
        if (faults == 0 && pose_q.size() == 0) begin
            $display("[differential_drive_odometry] OK");
        end else begin
            $display("[differential_drive_odometry] ERROR");
        end
        $finish;
    end

    initial begin : receiver
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                // hold off long enough for the block to back up into its input
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!steady && $urandom_range(0, 99) < 26) begin
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : scoreboard
        t_out want;
        t_pin pin;
        if (!i_rst_n) begin
            pose_x         = '0;
            pose_y         = '0;
            pose_heading   = '0;
            coef_half_dist = HALF_DIST_RST;
            coef_turn      = TURN_RST;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_HALF_DIST) begin
                    coef_half_dist = i_cfg_data;
                end else if (i_cfg_idx == CFG_TURN) begin
                    coef_turn = i_cfg_data;
                end
            end
            if (i_in_valid && !o_in_stall) begin
                want = advance_pose(i_in_data);
                pin  = fixed_q.pop_front();
                if (pin.pinned) begin
                    want = pin.pose;
                end
                pose_q.push_back(want);
            end
            if (o_out_valid && !i_out_stall) begin
                if (pose_q.size() == 0) begin
                    faults++;
                    if (faults <= 50)
                        $display("%0t: unexpected result x=%0d y=%0d heading=%0d", $time,
                                 o_out_data.pos_x, o_out_data.pos_y, o_out_data.heading);
                end else begin
                    want = pose_q.pop_front();
                    if (o_out_data.pos_x !== want.pos_x) begin
                        faults++;
                        if (faults <= 50)
                            $display("%0t: pos_x expected %0d, got %0d", $time,
                                     want.pos_x, o_out_data.pos_x);
                    end
                    if (o_out_data.pos_y !== want.pos_y) begin
                        faults++;
                        if (faults <= 50)
                            $display("%0t: pos_y expected %0d, got %0d", $time,
                                     want.pos_y, o_out_data.pos_y);
                    end
                    if (o_out_data.heading !== want.heading) begin
                        faults++;
                        if (faults <= 50)
                            $display("%0t: heading expected %0d, got %0d", $time,
                                     want.heading, o_out_data.heading);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[differential_drive_odometry] ERROR");
            $finish;
        end
    end

endmodule
